### hw/rtl/tvpc_pkg.sv
// ============================================================================
// tvpc_pkg: shared types and constants of the thermostat valve controller
// Level codes, field widths, settings limits and the small decision tables.
// ============================================================================
package tvpc_pkg;

    localparam int unsigned IN_DATA_W  = 96;
    localparam int unsigned OUT_DATA_W = 56;

    typedef logic [2:0] t_level;
    typedef logic [4:0] t_secs;

    localparam t_level LVL_OFF   = 3'd0;
    localparam t_level LVL_ONE   = 3'd1;
    localparam t_level LVL_TWO   = 3'd2;
    localparam t_level LVL_THREE = 3'd3;
    localparam t_level LVL_FULL  = 3'd4;
    localparam t_level LVL_BOOT  = 3'd6;

    localparam logic [1:0] WORK_COOL = 2'd0;
    localparam logic [1:0] WORK_HEAT = 2'd1;
    localparam logic [1:0] WORK_VENT = 2'd2;

    localparam logic signed [15:0] SET_MIN  = 16'sd100;
    localparam logic signed [15:0] SET_MAX  = 16'sd350;
    localparam logic signed [15:0] COMP_MIN = -16'sd100;
    localparam logic signed [15:0] COMP_MAX = 16'sd100;

    localparam logic signed [13:0] DIFF_HIGH = 14'sd30;
    localparam logic signed [13:0] DIFF_MID  = 14'sd10;
    localparam logic signed [13:0] DIFF_LOW  = -14'sd10;

    // Drive pulse length that follows a change to the given level.
    function automatic t_secs pulse_for(input t_level lv);
        t_secs secs;
        case (lv)
            LVL_ONE:   secs = 5'd6;
            LVL_TWO:   secs = 5'd11;
            LVL_THREE: secs = 5'd16;
            default:   secs = 5'd20;
        endcase
        return secs;
    endfunction

    // Automatic level with hysteresis; diff is the signed demand for the mode.
    function automatic t_level auto_level(input t_level cur, input logic [1:0] mode,
                                          input logic signed [13:0] diff);
        t_level nl;
        if (mode != WORK_COOL && mode != WORK_HEAT) begin
            nl = LVL_FULL;
        end else if (cur == LVL_ONE) begin
            nl = (diff <= DIFF_MID) ? LVL_TWO : LVL_ONE;
        end else if (cur == LVL_TWO) begin
            if (diff > DIFF_HIGH)
                nl = LVL_ONE;
            else if (diff <= DIFF_LOW)
                nl = LVL_FULL;
            else
                nl = LVL_TWO;
        end else if (diff > DIFF_HIGH) begin
            nl = LVL_ONE;
        end else if (diff > DIFF_MID) begin
            nl = LVL_TWO;
        end else begin
            nl = LVL_FULL;
        end
        return nl;
    endfunction

endpackage

### hw/rtl/thermostat_valve_pulse_controller_unit.sv
// ============================================================================
// thermostat_valve_pulse_controller_unit: one-second tick valve controller
// Clamps the settings words, forms the display temperature and runs the
// power-on boot hold and the level-change drive pulses of the valve.
// ============================================================================
//
//  Channel   | Direction | Handshake                  | Payload
//  ----------+-----------+----------------------------+---------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_..tready | one tick: settings, sensor
//  m_axis    | out       | o_m_axis_tvalid/i_..tready | one result per tick
//
//  An accepted item lands in the input register and moves on to the result
//  register whenever the output is not stalled, so one item is taken in every
//  cycle while the output does not stall. The level, pulse and drive state load
//  together with the result register, so the next item already sees them. A
//  stalled output holds its result while the input register takes one more item.
//  Reset (synchronous, active low) empties both registers and turns the valve off.
//
module thermostat_valve_pulse_controller_unit #(
    parameter int unsigned BOOT_HOLD_SECONDS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata from bit 0: power_request[15:0], fan_select[31:16],
    // work_mode_sel[47:32], setpoint[63:48], temp_comp[79:64],
    // sensor_temp[91:80], zero fill[95:92]
    input  logic [tvpc_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata from bit 0: valve_drive[0], level_shown[3:1], seconds_left[8:4],
    // display_temp[21:9], power_now[22], fan_select_now[25:23],
    // work_mode_now[27:26], setpoint_now[36:28], temp_comp_now[44:37],
    // settings_fixed[49:45], zero fill[55:50]
    output logic [tvpc_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);
    import tvpc_pkg::*;

    // Pipeline registers.
    logic                  r_in_valid;
    logic [IN_DATA_W-1:0]  r_in_data;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Controller state.
    t_level r_level, n_level;
    t_secs  r_pulse, n_pulse;
    logic   r_drive, n_drive;

    logic advance;
    logic in_accept;

    // Fields of the registered tick.
    logic [15:0]        f_pwr, f_fan, f_mode;
    logic signed [15:0] f_set, f_comp;
    logic signed [11:0] f_sensor;

    // Corrected settings.
    logic               pwr_c;
    logic [2:0]         fan_c;
    logic [1:0]         mode_c;
    logic signed [15:0] set_c, comp_c;
    logic [4:0]         fixed;
    logic signed [12:0] disp;
    logic signed [13:0] diff;
    t_level             new_level;
    logic [2:0]         level_shown;
    logic [OUT_DATA_W-1:0] result;

    // The result register advances when it is empty or being drained; the
    // input register can take a new item when it is empty or its contents move on.
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    assign f_pwr    = r_in_data[15:0];
    assign f_fan    = r_in_data[31:16];
    assign f_mode   = r_in_data[47:32];
    assign f_set    = r_in_data[63:48];
    assign f_comp   = r_in_data[79:64];
    assign f_sensor = r_in_data[91:80];

    // Settings clamp and correction flags, then the display temperature.
    always_comb begin
        fixed  = '0;
        pwr_c  = (f_pwr == 16'd1);
        fixed[0] = (f_pwr > 16'd1);
        if (f_fan > 16'd5) begin
            fan_c    = 3'd0;
            fixed[1] = 1'b1;
        end else begin
            fan_c = f_fan[2:0];
        end
        if (f_mode > 16'd2) begin
            mode_c   = WORK_COOL;
            fixed[2] = 1'b1;
        end else begin
            mode_c = f_mode[1:0];
        end
        if (f_set < SET_MIN) begin
            set_c    = SET_MIN;
            fixed[3] = 1'b1;
        end else if (f_set > SET_MAX) begin
            set_c    = SET_MAX;
            fixed[3] = 1'b1;
        end else begin
            set_c = f_set;
        end
        if (f_comp < COMP_MIN) begin
            comp_c   = COMP_MIN;
            fixed[4] = 1'b1;
        end else if (f_comp > COMP_MAX) begin
            comp_c   = COMP_MAX;
            fixed[4] = 1'b1;
        end else begin
            comp_c = f_comp;
        end
        disp = 13'(f_sensor) + 13'(comp_c);
        // Demand: how far the room is from the set point in the active mode.
        if (mode_c == WORK_HEAT)
            diff = 14'(disp) - 14'(set_c);
        else
            diff = 14'(set_c) - 14'(disp);
    end

    // Level, pulse and valve update for the registered tick.
    always_comb begin
        n_level   = r_level;
        n_pulse   = r_pulse;
        n_drive   = r_drive;
        new_level = (fan_c != 3'd0) ? fan_c : auto_level(r_level, mode_c, diff);
        if (!pwr_c) begin
            n_level = LVL_OFF;
            n_pulse = '0;
            n_drive = 1'b0;
        end else if (r_level == LVL_OFF) begin
            // Power-on edge: full-drive boot hold, fan written back as auto.
            n_level = LVL_BOOT;
            n_pulse = 5'(BOOT_HOLD_SECONDS);
            n_drive = 1'b1;
        end else if (r_level == LVL_BOOT) begin
            if (r_pulse != '0) begin
                n_pulse = r_pulse - 5'd1;
                if (r_pulse == 5'd1) begin
                    n_drive = 1'b0;
                    n_level = LVL_FULL;
                end
            end
        end else if (new_level != r_level) begin
            n_level = new_level;
            n_pulse = pulse_for(new_level);
            n_drive = 1'b1;
        end else if (r_pulse != '0) begin
            n_pulse = r_pulse - 5'd1;
            if (r_pulse == 5'd1)
                n_drive = 1'b0;
        end
    end

    // Result packing; the power-on edge forces the reported fan to auto.
    always_comb begin
        logic       boot_edge;
        logic [2:0] fan_out;
        logic [4:0] fixed_out;
        boot_edge = pwr_c && (r_level == LVL_OFF);
        fan_out   = boot_edge ? 3'd0 : fan_c;
        fixed_out = fixed | (boot_edge ? 5'b00010 : 5'b00000);
        if (n_level == LVL_OFF)
            level_shown = 3'd0;
        else if (n_level == LVL_BOOT)
            level_shown = LVL_FULL;
        else
            level_shown = n_level;
        result = {6'd0, fixed_out, comp_c[7:0], set_c[8:0], mode_c, fan_out,
                  pwr_c, disp, n_pulse, level_shown, n_drive};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= LVL_OFF;
            r_pulse     <= '0;
            r_drive     <= 1'b0;
        end else begin
            if (in_accept)
                r_in_valid <= 1'b1;
            else if (advance)
                r_in_valid <= 1'b0;
            if (advance)
                r_out_valid <= r_in_valid;
            if (advance && r_in_valid) begin
                r_level <= n_level;
                r_pulse <= n_pulse;
                r_drive <= n_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept)
            r_in_data <= i_s_axis_tdata;
        if (advance && r_in_valid)
            r_out_data <= result;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

### hw/rtl/tvpc_checker.sv
// ============================================================================
// tvpc_checker: port-level checks of the thermostat valve controller
// Watches the result stream for valve, level and settings consistency.
// ============================================================================
module tvpc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [tvpc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import tvpc_pkg::*;

    // No result survives a reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // The valve is driven exactly while pulse seconds remain.
    a_drive_secs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[0] == (o_m_axis_tdata[8:4] != 5'd0)))
        else $error("valve drive and seconds left disagree");

    // Power off shows the off level with the valve closed.
    a_off_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[22] |->
            (o_m_axis_tdata[3:1] == LVL_OFF) && !o_m_axis_tdata[0])
        else $error("output active while power is off");

    // A corrected power word always reads as off.
    a_pwr_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[45] |-> !o_m_axis_tdata[22])
        else $error("flagged power word reported on");

endmodule

bind thermostat_valve_pulse_controller_unit tvpc_checker u_tvpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

### bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the thermostat valve pulse controller
// Walks a short table of directed ticks, then random ticks with and without
// idling on both streams, and compares every result item against a
// cycle-free model of the clamping, boot hold and level pulse logic.
// ============================================================================
module tb;

    import tvpc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 4;
    localparam int BOOT_SECS    = 20;
    localparam int RANDOM_TICKS = 1200;
    localparam int PHASES       = 5;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;

    // Idle percentages per random phase: quiet, sender gaps, receiver stalls,
    // both, then quiet again so the tail drains at full rate.
    localparam int GAP_PCT   [PHASES] = '{0, 57, 0, 25, 0};
    localparam int STALL_PCT [PHASES] = '{0, 0, 57, 25, 0};

    // Write-back mask bits.
    localparam logic [4:0] FIX_PWR  = 5'b00001;
    localparam logic [4:0] FIX_FAN  = 5'b00010;
    localparam logic [4:0] FIX_MODE = 5'b00100;
    localparam logic [4:0] FIX_SET  = 5'b01000;
    localparam logic [4:0] FIX_COMP = 5'b10000;

    // Auto level thresholds on the demand (set minus display when cooling).
    localparam int DEMAND_HIGH = 30;
    localparam int DEMAND_MID  = 10;
    localparam int DEMAND_LOW  = -10;

    localparam t_secs PULSE_ONE   = 5'd6;
    localparam t_secs PULSE_TWO   = 5'd11;
    localparam t_secs PULSE_THREE = 5'd16;
    localparam t_secs PULSE_LONG  = 5'd20;

    // One tick item; the first member lands in the top bits.
    typedef struct packed {
        logic signed [11:0] sensor_temp;
        logic signed [15:0] temp_comp;
        logic signed [15:0] setpoint;
        logic [15:0]        work_mode_sel;
        logic [15:0]        fan_select;
        logic [15:0]        power_request;
    } t_tick;

    // One result item, laid out as the output tdata from the top down.
    typedef struct packed {
        logic [4:0]         settings_fixed;
        logic signed [7:0]  temp_comp_now;
        logic [8:0]         setpoint_now;
        logic [1:0]         work_mode_now;
        logic [2:0]         fan_select_now;
        logic               power_now;
        logic signed [12:0] display_temp;
        logic [4:0]         seconds_left;
        logic [2:0]         level_shown;
        logic               valve_drive;
    } t_report;

    // Directed row: tick fields, repeat count, whether a result is typed in,
    // then the typed result (drive, level, seconds, display, power, fan, mode,
    // set temp, comp, mask).
    typedef struct {
        int pwr, fan, mode, setp, comp, sensor, reps, typed;
        int e_drive, e_level, e_secs, e_disp, e_pwr, e_fan, e_mode, e_set, e_comp, e_fixed;
    } t_plan_row;

    localparam int PLAN_ROWS = 25;

    t_plan_row plan [PLAN_ROWS] = '{
        // Power off with every setting at its low extreme.
        '{0, 0, 0, -32768, -32768, -1000, 1, 1,
          0, LVL_OFF, 0, -1100, 0, 0, WORK_COOL, 100, -100, FIX_SET | FIX_COMP},
        // Every raw word at its top value: power counts as off, all corrected.
        '{65535, 65535, 65535, 32767, 32767, 2000, 1, 1,
          0, LVL_OFF, 0, 2100, 0, 0, WORK_COOL, 350, 100, 5'b11111},
        // Each setting one step outside its legal range.
        '{2, 6, 3, 99, -101, 0, 1, 1,
          0, LVL_OFF, 0, -100, 0, 0, WORK_COOL, 100, -100, 5'b11111},
        // Power-on edge: boot hold starts and the fan word is forced to auto.
        '{1, 3, 1, 250, 0, 250, 1, 1,
          1, LVL_FULL, BOOT_SECS, 250, 1, 0, WORK_HEAT, 250, 0, FIX_FAN},
        // Boot hold ticks carry the in-range extremes; choices are ignored.
        '{1, 5, 2, 100, -100, -1000, 1, 1,
          1, LVL_FULL, BOOT_SECS - 1, -1100, 1, 5, WORK_VENT, 100, -100, 0},
        '{1, 0, 0, 350, 100, 2000, 1, 1,
          1, LVL_FULL, BOOT_SECS - 2, 2100, 1, 0, WORK_COOL, 350, 100, 0},
        '{1, 0, 0, 101, 99, 5, BOOT_SECS - 3, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // Last boot tick: valve off, level settles at full.
        '{1, 0, 0, 349, -99, -5, 1, 1,
          0, LVL_FULL, 0, -104, 1, 0, WORK_COOL, 349, -99, 0},
        // Manual levels, each change restarting its pulse.
        '{1, 1, 0, 200, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 1, 0, 200, 0, 200, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 2, 0, 200, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 3, 0, 200, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 4, 0, 200, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 5, 0, 200, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // Auto in vent mode always asks for the full level.
        '{1, 0, 2, 200, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // Auto cooling hysteresis around the thresholds.
        '{1, 0, 0, 300, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 220, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 210, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 230, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 231, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 205, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // Heating flips the sign of the demand.
        '{1, 0, 1, 210, 0, 200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 1, 210, 0, 221, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // Power drops in the middle of a pulse, then comes back.
        '{0, 0, 1, 210, 0, 221, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 1, 210, 0, 221, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // Model copy of the controller state.
    t_level ctl_level;
    t_secs  ctl_secs;
    logic   ctl_drive;

    t_report valve_reports_due[$];
    int      mismatch_count;
    int      gap_pct;
    int      stall_pct;
    bit      long_hold_req;
    int      hold_left;
    int      cycle_count;

    thermostat_valve_pulse_controller_unit #(
        .BOOT_HOLD_SECONDS(BOOT_SECS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // Advances the model by one tick and returns the report it should produce.
    function automatic t_report step_thermostat(input t_tick t);
        t_report     r;
        logic [15:0] pwr;
        logic [15:0] fan;
        logic [15:0] mode;
        logic [4:0]  fixed;
        int          set_c;
        int          comp_c;
        int          disp;
        int          demand;
        t_level      pick;
        pwr    = t.power_request;
        fan    = t.fan_select;
        mode   = t.work_mode_sel;
        set_c  = int'(t.setpoint);
        comp_c = int'(t.temp_comp);
        fixed  = '0;
        if (pwr > 1) begin
            pwr = '0;
            fixed |= FIX_PWR;
        end
        if (fan > 5) begin
            fan = '0;
            fixed |= FIX_FAN;
        end
        if (mode > WORK_VENT) begin
            mode = WORK_COOL;
            fixed |= FIX_MODE;
        end
        if (set_c < SET_MIN) begin
            set_c = SET_MIN;
            fixed |= FIX_SET;
        end else if (set_c > SET_MAX) begin
            set_c = SET_MAX;
            fixed |= FIX_SET;
        end
        if (comp_c < COMP_MIN) begin
            comp_c = COMP_MIN;
            fixed |= FIX_COMP;
        end else if (comp_c > COMP_MAX) begin
            comp_c = COMP_MAX;
            fixed |= FIX_COMP;
        end
        disp = int'(t.sensor_temp) + comp_c;

        if (pwr == 0) begin
            ctl_level = LVL_OFF;
            ctl_secs  = '0;
            ctl_drive = 1'b0;
        end else if (ctl_level == LVL_OFF) begin
            // Power-on edge: the fan word is written back as auto.
            fan = '0;
            fixed |= FIX_FAN;
            ctl_level = LVL_BOOT;
            ctl_secs  = t_secs'(BOOT_SECS);
            ctl_drive = 1'b1;
        end else if (ctl_level == LVL_BOOT) begin
            if (ctl_secs != 0) begin
                ctl_secs--;
                if (ctl_secs == 0) begin
                    ctl_drive = 1'b0;
                    ctl_level = LVL_FULL;
                end
            end
        end else begin
            if (fan >= 1 && fan <= 5) begin
                pick = fan[2:0];
            end else if (mode == WORK_VENT) begin
                pick = LVL_FULL;
            end else begin
                demand = (mode == WORK_COOL) ? set_c - disp : disp - set_c;
                if (ctl_level == LVL_ONE)
                    pick = (demand <= DEMAND_MID) ? LVL_TWO : LVL_ONE;
                else if (ctl_level == LVL_TWO)
                    pick = (demand > DEMAND_HIGH) ? LVL_ONE :
                           (demand <= DEMAND_LOW) ? LVL_FULL : LVL_TWO;
                else
                    pick = (demand > DEMAND_HIGH) ? LVL_ONE :
                           (demand > DEMAND_MID)  ? LVL_TWO : LVL_FULL;
            end
            if (pick != ctl_level) begin
                ctl_level = pick;
                case (pick)
                    LVL_ONE:   ctl_secs = PULSE_ONE;
                    LVL_TWO:   ctl_secs = PULSE_TWO;
                    LVL_THREE: ctl_secs = PULSE_THREE;
                    default:   ctl_secs = PULSE_LONG;
                endcase
                ctl_drive = 1'b1;
            end else if (ctl_secs != 0) begin
                ctl_secs--;
                if (ctl_secs == 0)
                    ctl_drive = 1'b0;
            end
        end

        r.valve_drive    = ctl_drive;
        r.level_shown    = (ctl_level == LVL_BOOT) ? LVL_FULL : ctl_level;
        r.seconds_left   = ctl_secs;
        r.display_temp   = disp[12:0];
        r.power_now      = pwr[0];
        r.fan_select_now = fan[2:0];
        r.work_mode_now  = mode[1:0];
        r.setpoint_now   = set_c[8:0];
        r.temp_comp_now  = comp_c[7:0];
        r.settings_fixed = fixed;
        return r;
    endfunction

    // Mostly powered ticks with legal settings and a sensor reading close to
    // the set point, so the boot hold ends and the hysteresis gets exercised;
    // the rest is out-of-range words and power drops.
    function automatic t_tick random_tick();
        t_tick t;
        int    set_c;
        int    comp_c;
        int    roll;
        roll = $urandom_range(99);
        if (roll < 3)
            t.power_request = '0;
        else if (roll < 5)
            t.power_request = 16'($urandom_range(65535, 2));
        else
            t.power_request = 16'd1;
        roll = $urandom_range(99);
        if (roll < 60)
            t.fan_select = '0;
        else if (roll < 90)
            t.fan_select = 16'($urandom_range(5, 1));
        else
            t.fan_select = 16'($urandom_range(65535, 6));
        if ($urandom_range(99) < 90)
            t.work_mode_sel = 16'($urandom_range(2));
        else
            t.work_mode_sel = 16'($urandom_range(65535, 3));
        if ($urandom_range(99) < 85)
            t.setpoint = 16'($urandom_range(350, 100));
        else
            t.setpoint = 16'($urandom);
        if ($urandom_range(99) < 85)
            t.temp_comp = 16'(int'($urandom_range(200)) - 100);
        else
            t.temp_comp = 16'($urandom);
        set_c  = int'(t.setpoint);
        comp_c = int'(t.temp_comp);
        set_c  = (set_c < SET_MIN) ? SET_MIN : (set_c > SET_MAX) ? SET_MAX : set_c;
        comp_c = (comp_c < COMP_MIN) ? COMP_MIN : (comp_c > COMP_MAX) ? COMP_MAX : comp_c;
        if ($urandom_range(99) < 80)
            t.sensor_temp = 12'(set_c - comp_c + int'($urandom_range(90)) - 45);
        else
            t.sensor_temp = 12'(int'($urandom_range(3000)) - 1000);
        return t;
    endfunction

    // Offers one tick, waits for it to be taken, then records what it should
    // produce. Valid is left high after acceptance so back-to-back items never
    // see a low and a high assigned in the same step.
    task automatic send_tick(input t_tick t, input bit use_typed, input t_report typed_rep);
        t_report predicted;
        while ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_DATA_W - $bits(t_tick)){1'b0}}, t};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = step_thermostat(t);
        valve_reports_due.push_back(use_typed ? typed_rep : predicted);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Stimulus: reset, directed table, then the random phases.
    initial begin
        t_tick   t;
        t_report typed_rep;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        gap_pct         = 0;
        stall_pct       = 0;
        long_hold_req   = 1'b0;
        mismatch_count  = 0;
        ctl_level       = LVL_OFF;
        ctl_secs        = '0;
        ctl_drive       = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            t.power_request = plan[i].pwr[15:0];
            t.fan_select    = plan[i].fan[15:0];
            t.work_mode_sel = plan[i].mode[15:0];
            t.setpoint      = plan[i].setp[15:0];
            t.temp_comp     = plan[i].comp[15:0];
            t.sensor_temp   = plan[i].sensor[11:0];
            typed_rep.valve_drive    = plan[i].e_drive[0];
            typed_rep.level_shown    = plan[i].e_level[2:0];
            typed_rep.seconds_left   = plan[i].e_secs[4:0];
            typed_rep.display_temp   = plan[i].e_disp[12:0];
            typed_rep.power_now      = plan[i].e_pwr[0];
            typed_rep.fan_select_now = plan[i].e_fan[2:0];
            typed_rep.work_mode_now  = plan[i].e_mode[1:0];
            typed_rep.setpoint_now   = plan[i].e_set[8:0];
            typed_rep.temp_comp_now  = plan[i].e_comp[7:0];
            typed_rep.settings_fixed = plan[i].e_fixed[4:0];
            repeat (plan[i].reps) send_tick(t, plan[i].typed != 0, typed_rep);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            gap_pct   = GAP_PCT[ph];
            stall_pct = STALL_PCT[ph];
            // In quiet phases the receiver first holds off for a long stretch
            // while items keep coming, so both stages fill and input backs up.
            if (gap_pct == 0 && stall_pct == 0)
                long_hold_req = 1'b1;
            for (int n = 0; n < RANDOM_TICKS / PHASES; n++)
                send_tick(random_tick(), 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;

        while (valve_reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("thermostat_valve_pulse_controller_unit regression: pass");
        else
            $display("thermostat_valve_pulse_controller_unit regression: fail");
        $finish;
    end

    // Receiver: random stalls per phase, plus the long hold-off counted here.
    initial begin
        i_m_axis_tready = 1'b0;
        hold_left       = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                hold_left     = HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= !($urandom_range(99) < stall_pct);
            end
        end
    end

    // Result checker: each accepted item against the oldest expectation.
    always @(posedge i_clk) begin
        t_report seen;
        t_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen = o_m_axis_tdata[$bits(t_report)-1:0];
            if (valve_reports_due.size() == 0) begin
                $error("result item arrived with no tick outstanding");
                mismatch_count++;
            end else begin
                want = valve_reports_due.pop_front();
                check_field("valve_drive", int'(want.valve_drive), int'(seen.valve_drive));
                check_field("level_shown", int'(want.level_shown), int'(seen.level_shown));
                check_field("seconds_left", int'(want.seconds_left),
                            int'(seen.seconds_left));
                check_field("display_temp", int'(want.display_temp),
                            int'(seen.display_temp));
                check_field("power_now", int'(want.power_now), int'(seen.power_now));
                check_field("fan_select_now", int'(want.fan_select_now),
                            int'(seen.fan_select_now));
                check_field("work_mode_now", int'(want.work_mode_now),
                            int'(seen.work_mode_now));
                check_field("setpoint_now", int'(want.setpoint_now),
                            int'(seen.setpoint_now));
                check_field("temp_comp_now", int'(want.temp_comp_now),
                            int'(seen.temp_comp_now));
                check_field("settings_fixed", int'(want.settings_fixed),
                            int'(seen.settings_fixed));
            end
        end
    end

    // Watchdog in case the block hangs.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("thermostat_valve_pulse_controller_unit regression: fail");
                $finish;
            end
        end
    end

endmodule

### files.f
hw/rtl/tvpc_pkg.sv
hw/rtl/thermostat_valve_pulse_controller_unit.sv
hw/rtl/tvpc_checker.sv
bench/tb.sv
